// File: design/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// shared types, character codes and helpers for the s-expression token scanner
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int LINE_BITS   = 16;
   localparam int COLUMN_BITS = 16;
   localparam int NEST_BITS   = 8;

   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam int OUT_POS_BITS     = 16;
   localparam int REC_PAYLOAD_BITS = 8 + 3 + 2 + 4 * OUT_POS_BITS;
   localparam int RSP_DATA_BITS    = ((REC_PAYLOAD_BITS + 7) / 8) * 8;

   typedef logic [LINE_BITS-1:0]   line_type;
   typedef logic [COLUMN_BITS-1:0] col_type;
   typedef logic [NEST_BITS-1:0]   nest_type;

   localparam line_type LINE_TOP = '1;
   localparam col_type  COL_TOP  = '1;
   localparam nest_type NEST_TOP = '1;

   // character codes
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef enum logic [2:0] {
      MODE_NORMAL,
      MODE_LINE,
      MODE_BLOCK,
      MODE_DROP,
      MODE_STR,
      MODE_ESC
   } mode_type;

   typedef enum logic [2:0] {
      TK_LPAREN,
      TK_RPAREN,
      TK_SYMBOL,
      TK_STRING,
      TK_INT,
      TK_FLOAT,
      TK_EOF,
      TK_NONE
   } tok_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_UNTERM_STRING,
      ERR_BAD_FLOAT,
      ERR_BAD_INT
   } err_type;

   typedef enum logic {
      REC_CHAR,
      REC_END
   } rec_kind_type;

   typedef struct packed {
      logic digit;
      logic bad;
      logic dot;
   } numflag_type;

   typedef struct packed {
      logic                    record_kind;
      logic [7:0]              char_value;
      logic [2:0]              token_kind;
      logic [1:0]              error_code;
      logic [OUT_POS_BITS-1:0] begin_line;
      logic [OUT_POS_BITS-1:0] begin_column;
      logic [OUT_POS_BITS-1:0] end_line;
      logic [OUT_POS_BITS-1:0] end_column;
      logic                    last_of_run;
   } rec_type;

   // records produced by one scanner step, count of valid entries from the bottom
   typedef struct packed {
      logic [1:0]                count;
      rec_type [MAX_RESULTS-1:0] rec;
   } batch_type;

   function automatic logic is_blank(input logic [7:0] ch);
      return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return (ch >= CH_ZERO) && (ch <= CH_NINE);
   endfunction

   function automatic line_type line_inc(input line_type x);
      return (x == LINE_TOP) ? x : x + line_type'(1);
   endfunction

   function automatic col_type col_inc(input col_type x);
      return (x == COL_TOP) ? x : x + col_type'(1);
   endfunction

   function automatic logic [OUT_POS_BITS-1:0] pos_out(input logic [31:0] x);
      return x[OUT_POS_BITS-1:0];
   endfunction

   function automatic rec_type char_rec(input logic [7:0] ch);
      rec_type r;
      r = '0;
      r.record_kind = REC_CHAR;
      r.char_value  = ch;
      return r;
   endfunction

   function automatic rec_type end_rec(input tok_type tk, input err_type err,
                                       input line_type bl, input col_type bc,
                                       input line_type el, input col_type ec);
      rec_type r;
      r = '0;
      r.record_kind  = REC_END;
      r.token_kind   = 3'(tk);
      r.error_code   = 2'(err);
      r.begin_line   = pos_out(32'(bl));
      r.begin_column = pos_out(32'(bc));
      r.end_line     = pos_out(32'(el));
      r.end_column   = pos_out(32'(ec));
      return r;
   endfunction

endpackage

// File: design/sexpr_token_scanner_core.sv
// ----------------------------------------------------------------------------
// sexpr_token_scanner_core
// streaming lexer for s-expression source text, one byte per transfer
// ----------------------------------------------------------------------------
// Each req transfer carries one source byte, or an end-of-input mark in
// req_tuser. The scanner emits every token character as a rsp record of kind 0
// as soon as it is known to belong to a token, and closes every token with a
// kind 1 record giving token type, error code and begin/end line and column
// (saturating, lines and columns start at 1). Line comments, nested block
// comments, string escapes, the hash-backslash character literal and number
// checks are handled internally. rsp_tlast marks the last record caused by a
// byte; a byte may cause no record at all (blanks, comments). A byte waits in
// the input register until the output queue has room, and its records are
// written into the output queue when it steps, so rsp is driven from the
// queue register. The input accepts one byte per cycle as long as the
// 8-entry output queue keeps at least three free slots; since rsp drains
// one record per cycle while rsp_tready is high, the sustained rate is one
// byte per cycle when bytes average one record or fewer, and otherwise is
// set by the record count (up to three per byte, e.g. a lone hash closed by
// a paren).
// ----------------------------------------------------------------------------
module sexpr_token_scanner_core import sts_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request side
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,  // [7:0] byte_value
   input  logic                     req_tuser,  // [0] end_of_input
   // response side
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // [7:0] char_value, [10:8] token_kind,
                                                // [12:11] error_code, [28:13] begin_line,
                                                // [44:29] begin_column, [60:45] end_line,
                                                // [76:61] end_column, rest zero
   output logic                     rsp_tuser,  // [0] record_kind
   output logic                     rsp_tlast   // last record of this byte
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eoi_ff;

   logic       room;
   logic       step_en;
   logic       req_take;
   batch_type  batch;
   rec_type    head;

   // step only when the queue can absorb a worst-case burst of records
   assign step_en    = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take)     in_valid_in = 1'b1;
      else if (step_en) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_eoi_ff  <= req_tuser;
      end
   end

   sts_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .step_en      (step_en),
      .byte_value   (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .batch        (batch)
   );

   sts_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .batch     (batch),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (head)
   );

   // pack the head record onto the response bus
   assign rsp_tdata = RSP_DATA_BITS'({head.end_column, head.end_line, head.begin_column,
                                      head.begin_line, head.error_code, head.token_kind,
                                      head.char_value});
   assign rsp_tuser = head.record_kind;
   assign rsp_tlast = head.last_of_run;

   // end of input always produces at least the eof record
   a_eoi_records: assert property (@(posedge clock) disable iff (reset)
      step_en && in_eoi_ff |-> batch.count != 2'd0)
      else $error("end of input produced no record");

endmodule

// File: design/sts_scan.sv
// ----------------------------------------------------------------------------
// sts_scan
// scanner state and single-pass step logic, up to three records per byte
// ----------------------------------------------------------------------------
module sts_scan import sts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] byte_value,
   input  logic       end_of_input,
   output batch_type  batch
);

   mode_type    mode_ff, mode_in;
   tok_type     kind_ff, kind_in;
   logic [1:0]  tlen_ff, tlen_in;
   logic [15:0] first_ff, first_in;
   nest_type    depth_ff, depth_in;
   logic [7:0]  prev_ff, prev_in;
   numflag_type flags_ff, flags_in;
   line_type    bl_ff, bl_in, el_ff, el_in;
   col_type     bc_ff, bc_in, ec_ff, ec_in;

   rec_type     rec_c [0:MAX_RESULTS-1];
   logic [1:0]  n_c;
   logic        hash_only, char_lit, is_delim, hold_c, bad_c;
   logic        do_hash, do_close, do_eof, do_start, do_append;
   tok_type     tk_c;
   err_type     err_c;

   assign hash_only = (kind_ff == TK_SYMBOL) && (tlen_ff == 2'd1) && (first_ff[7:0] == CH_HASH);
   assign char_lit  = (tlen_ff == 2'd2) && (first_ff == {CH_BSLASH, CH_HASH});
   assign is_delim  = (byte_value == CH_SEMI) || (byte_value == CH_QUOTE) ||
                      (byte_value == CH_LPAREN) || (byte_value == CH_RPAREN);

   always_comb begin
      mode_in  = mode_ff;
      kind_in  = kind_ff;
      tlen_in  = tlen_ff;
      first_in = first_ff;
      depth_in = depth_ff;
      prev_in  = prev_ff;
      flags_in = flags_ff;
      bl_in    = bl_ff;
      bc_in    = bc_ff;
      el_in    = el_ff;
      ec_in    = ec_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         rec_c[i] = '0;
      end
      n_c       = 2'd0;
      do_hash   = 1'b0;
      do_close  = 1'b0;
      do_eof    = 1'b0;
      do_start  = 1'b0;
      do_append = 1'b0;
      hold_c    = 1'b0;
      bad_c     = 1'b0;
      tk_c      = TK_NONE;
      err_c     = ERR_NONE;

      // mode specific part
      if (end_of_input) begin
         case (mode_ff)
            MODE_LINE: begin
               el_in = line_inc(el_in);
               ec_in = col_type'(1);
               bc_in = col_type'(1);
            end
            MODE_BLOCK: begin
               ec_in = col_type'(1);
               bc_in = col_type'(1);
            end
            MODE_STR, MODE_ESC: begin
               if (n_c < 2'd3) rec_c[n_c] = end_rec(TK_STRING, ERR_UNTERM_STRING,
                                                    bl_in, bc_in, el_in, ec_in);
               n_c   = n_c + 2'd1;
               bl_in = el_in;
               bc_in = ec_in;
            end
            MODE_DROP: begin
            end
            default: begin
               if (kind_ff != TK_NONE) begin
                  do_hash  = hash_only;
                  do_close = 1'b1;
               end
            end
         endcase
         do_eof = 1'b1;
      end else begin
         case (mode_ff)
            MODE_LINE: begin
               if (byte_value == CH_NL) begin
                  el_in   = line_inc(el_in);
                  ec_in   = col_type'(1);
                  bc_in   = col_type'(1);
                  mode_in = MODE_NORMAL;
               end
            end
            MODE_BLOCK: begin
               if (byte_value == CH_NL) begin
                  el_in = line_inc(el_in);
                  ec_in = col_type'(1);
               end else begin
                  ec_in = col_inc(ec_in);
               end
               if ((prev_ff == CH_BAR) && (byte_value == CH_HASH)) begin
                  if (depth_in != '0) depth_in = depth_in - nest_type'(1);
               end else if ((prev_ff == CH_HASH) && (byte_value == CH_BAR)) begin
                  if (depth_in != NEST_TOP) depth_in = depth_in + nest_type'(1);
               end
               if (depth_in == '0) begin
                  ec_in   = col_type'(1);
                  bc_in   = col_type'(1);
                  mode_in = MODE_DROP;
               end else begin
                  prev_in = byte_value;
               end
            end
            MODE_DROP: begin
               // the character right after a block comment close is swallowed
               if (byte_value == CH_NL) el_in = line_inc(el_in);
               ec_in   = col_type'(1);
               mode_in = MODE_NORMAL;
            end
            MODE_STR: begin
               if (byte_value == CH_BSLASH) begin
                  mode_in = MODE_ESC;
               end else if (byte_value == CH_QUOTE) begin
                  ec_in = col_inc(ec_in);
                  if (n_c < 2'd3) rec_c[n_c] = end_rec(TK_STRING, ERR_NONE,
                                                       bl_in, bc_in, el_in, ec_in);
                  n_c      = n_c + 2'd1;
                  bl_in    = el_in;
                  bc_in    = ec_in;
                  kind_in  = TK_NONE;
                  tlen_in  = 2'd0;
                  first_in = '0;
                  flags_in = '0;
                  mode_in  = MODE_NORMAL;
               end else begin
                  if (n_c < 2'd3) rec_c[n_c] = char_rec(byte_value);
                  n_c = n_c + 2'd1;
                  if (byte_value == CH_NL) el_in = line_inc(el_in);
                  else                     ec_in = col_inc(ec_in);
               end
            end
            MODE_ESC: begin
               // escaped quote drops its backslash, anything else keeps it
               if (byte_value != CH_QUOTE) begin
                  if (n_c < 2'd3) rec_c[n_c] = char_rec(CH_BSLASH);
                  n_c   = n_c + 2'd1;
                  ec_in = col_inc(ec_in);
               end
               if (n_c < 2'd3) rec_c[n_c] = char_rec(byte_value);
               n_c = n_c + 2'd1;
               if (byte_value == CH_NL) el_in = line_inc(el_in);
               else                     ec_in = col_inc(ec_in);
               mode_in = MODE_STR;
            end
            default: begin
               mode_in = MODE_NORMAL;
               if (kind_ff == TK_NONE) begin
                  do_start = 1'b1;
               end else if (hash_only && (byte_value == CH_BAR)) begin
                  kind_in  = TK_NONE;
                  tlen_in  = 2'd0;
                  first_in = '0;
                  flags_in = '0;
                  mode_in  = MODE_BLOCK;
                  depth_in = nest_type'(1);
                  prev_in  = CH_BAR;
               end else begin
                  do_hash = hash_only;
                  if (is_blank(byte_value) || (!char_lit && is_delim)) begin
                     do_close = 1'b1;
                     do_start = 1'b1;
                  end else begin
                     do_append = 1'b1;
                  end
               end
            end
         endcase
      end

      // held-back hash is released
      if (do_hash) begin
         if (n_c < 2'd3) rec_c[n_c] = char_rec(CH_HASH);
         n_c = n_c + 2'd1;
      end

      // close the pending token, numbers get checked here
      if (do_close) begin
         tk_c  = kind_in;
         err_c = ERR_NONE;
         bad_c = flags_in.bad || !flags_in.digit;
         if (kind_in == TK_INT) begin
            if ((tlen_in == 2'd1) && (first_in[7:0] == CH_MINUS)) begin
               tk_c = TK_SYMBOL;
            end else if (flags_in.dot) begin
               tk_c  = TK_FLOAT;
               err_c = bad_c ? ERR_BAD_FLOAT : ERR_NONE;
            end else begin
               err_c = bad_c ? ERR_BAD_INT : ERR_NONE;
            end
         end
         if (n_c < 2'd3) rec_c[n_c] = end_rec(tk_c, err_c, bl_in, bc_in, el_in, ec_in);
         n_c      = n_c + 2'd1;
         bl_in    = el_in;
         bc_in    = ec_in;
         kind_in  = TK_NONE;
         tlen_in  = 2'd0;
         first_in = '0;
         flags_in = '0;
      end

      if (do_eof) begin
         kind_in  = TK_NONE;
         tlen_in  = 2'd0;
         first_in = '0;
         flags_in = '0;
         mode_in  = MODE_NORMAL;
         if (n_c < 2'd3) rec_c[n_c] = end_rec(TK_EOF, ERR_NONE, bl_in, bc_in, el_in, ec_in);
         n_c   = n_c + 2'd1;
         bl_in = el_in;
         bc_in = ec_in;
      end

      // fresh scan of a byte outside any token
      if (do_start) begin
         if (byte_value == CH_SEMI) begin
            mode_in = MODE_LINE;
         end else if (byte_value == CH_QUOTE) begin
            kind_in = TK_STRING;
            bl_in   = el_in;
            bc_in   = ec_in;
            mode_in = MODE_STR;
         end else if (is_blank(byte_value)) begin
            if (byte_value == CH_NL) begin
               el_in = line_inc(el_in);
               ec_in = col_type'(1);
               bc_in = col_type'(1);
            end else begin
               ec_in = col_inc(ec_in);
            end
         end else if ((byte_value == CH_LPAREN) || (byte_value == CH_RPAREN)) begin
            bl_in = el_in;
            bc_in = ec_in;
            ec_in = col_inc(ec_in);
            if (n_c < 2'd3) rec_c[n_c] = end_rec((byte_value == CH_LPAREN) ? TK_LPAREN
                                                                           : TK_RPAREN,
                                                 ERR_NONE, bl_in, bc_in, el_in, ec_in);
            n_c   = n_c + 2'd1;
            bl_in = el_in;
            bc_in = ec_in;
         end else begin
            kind_in   = ((byte_value == CH_MINUS) || is_digit(byte_value)) ? TK_INT
                                                                           : TK_SYMBOL;
            bl_in     = el_in;
            bc_in     = ec_in;
            do_append = 1'b1;
         end
      end

      // add one character to the token text
      if (do_append) begin
         hold_c = (tlen_in == 2'd0) && (byte_value == CH_HASH);
         if ((kind_in == TK_INT) && (tlen_in == 2'd1) && (first_in[7:0] == CH_MINUS) &&
             !is_digit(byte_value)) begin
            kind_in = TK_SYMBOL;
         end
         if (tlen_in == 2'd0)      first_in = {8'h00, byte_value};
         else if (tlen_in == 2'd1) first_in[15:8] = byte_value;
         if (is_digit(byte_value)) begin
            flags_in.digit = 1'b1;
         end else if ((tlen_in == 2'd0) && (byte_value == CH_MINUS)) begin
            flags_in.bad = flags_in.bad;
         end else if (byte_value == CH_DOT) begin
            if (flags_in.dot) flags_in.bad = 1'b1;
            else              flags_in.dot = 1'b1;
         end else begin
            flags_in.bad = 1'b1;
         end
         if (tlen_in != 2'd3) tlen_in = tlen_in + 2'd1;
         ec_in = col_inc(ec_in);
         if (!hold_c) begin
            if (n_c < 2'd3) rec_c[n_c] = char_rec(byte_value);
            n_c = n_c + 2'd1;
         end
      end

      if (n_c != 2'd0) rec_c[n_c - 2'd1].last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         kind_ff  <= TK_NONE;
         tlen_ff  <= 2'd0;
         first_ff <= '0;
         depth_ff <= '0;
         prev_ff  <= '0;
         flags_ff <= '0;
         bl_ff    <= line_type'(1);
         bc_ff    <= col_type'(1);
         el_ff    <= line_type'(1);
         ec_ff    <= col_type'(1);
      end else if (step_en) begin
         mode_ff  <= mode_in;
         kind_ff  <= kind_in;
         tlen_ff  <= tlen_in;
         first_ff <= first_in;
         depth_ff <= depth_in;
         prev_ff  <= prev_in;
         flags_ff <= flags_in;
         bl_ff    <= bl_in;
         bc_ff    <= bc_in;
         el_ff    <= el_in;
         ec_ff    <= ec_in;
      end
   end

   always_comb begin
      batch.count = step_en ? n_c : 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         batch.rec[i] = rec_c[i];
      end
   end

   // a block comment is only open while its nesting depth is nonzero
   a_block_depth: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_BLOCK |-> depth_ff != '0)
      else $error("block comment open with zero depth");

   // end of input leaves the scanner idle with no token pending
   a_eoi_idle: assert property (@(posedge clock) disable iff (reset)
      step_en && end_of_input |=> mode_ff == MODE_NORMAL && kind_ff == TK_NONE)
      else $error("scanner not idle after end of input");

endmodule

// File: design/sts_outq.sv
// ----------------------------------------------------------------------------
// sts_outq
// result queue, takes up to three records per cycle and hands out one while out_ready is high
// ----------------------------------------------------------------------------
module sts_outq import sts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  batch_type batch,
   output logic      room,
   output logic      out_valid,
   input  logic      out_ready,
   output rec_type   out_rec
);

   rec_type              q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_BITS:0]   cnt_ff, cnt_in;
   logic                 pop;

   assign out_valid = (cnt_ff != '0);
   assign out_rec   = q_ff[rd_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (cnt_ff <= (QPTR_BITS + 1)'(QUEUE_DEPTH - MAX_RESULTS));

   assign wr_in  = wr_ff + QPTR_BITS'(batch.count);
   assign rd_in  = rd_ff + QPTR_BITS'(pop);
   assign cnt_in = cnt_ff + (QPTR_BITS + 1)'(batch.count) - (QPTR_BITS + 1)'(pop);

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < batch.count) q_ff[wr_ff + QPTR_BITS'(i)] <= batch.rec[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_BITS + 1)'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      batch.count != 2'd0 |-> room)
      else $error("records pushed without room");

   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      QPTR_BITS'(wr_ff - rd_ff) == cnt_ff[QPTR_BITS-1:0])
      else $error("queue pointers disagree with count");

endmodule
